>>> rtl/core/md5_pkg.sv
// Package for the MD5 hash engine: state codes, round constants and helper
// functions. No dependencies; md5_hash_engine_top, md5_round and md5_blk_buf import it.
`default_nettype none

package md5_pkg;

    // Initial chaining vector.
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    // Padding marker byte and the byte position from which a second pad block is needed.
    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_START   = 6'd56;
    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [5:0] LAST_BYTE   = 6'd63;
    localparam logic [3:0] LEN_WORD_LO = 4'd14;
    localparam logic [3:0] LEN_WORD_HI = 4'd15;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_ZERO  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    // What follows the compression that is running.
    typedef enum logic [1:0] {
        BLK_DATA = 2'd0,
        BLK_PAD  = 2'd1,
        BLK_LAST = 2'd2
    } t_blk_kind;

    // Commands from the sequencer to the block buffer.
    typedef struct packed {
        logic        wr_byte;
        logic [5:0]  byte_pos;
        logic [7:0]  byte_val;
        logic        pad;
        logic [5:0]  pad_pos;
        logic        clear;
        logic        put_len;
        logic [63:0] bit_len;
    } t_buf_cmd;

    // Additive constants of the 64 rounds.
    localparam logic [31:0] K_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amount: four values per quarter, chosen by the low two round bits.
    function automatic logic [4:0] f_rot_amount(input logic [5:0] rnd);
        logic [4:0] amt;
        amt = 5'd0;
        unique case ({rnd[5:4], rnd[1:0]})
            4'b0000: amt = 5'd7;
            4'b0001: amt = 5'd12;
            4'b0010: amt = 5'd17;
            4'b0011: amt = 5'd22;
            4'b0100: amt = 5'd5;
            4'b0101: amt = 5'd9;
            4'b0110: amt = 5'd14;
            4'b0111: amt = 5'd20;
            4'b1000: amt = 5'd4;
            4'b1001: amt = 5'd11;
            4'b1010: amt = 5'd16;
            4'b1011: amt = 5'd23;
            4'b1100: amt = 5'd6;
            4'b1101: amt = 5'd10;
            4'b1110: amt = 5'd15;
            default: amt = 5'd21;
        endcase
        return amt;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/md5_if.sv
// Stream interfaces of the MD5 hash engine: byte input and digest output.
// Depends on nothing else.
`default_nettype none

interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    modport source (output valid, output digest_low, output digest_high, input ready);
    modport sink   (input valid, input digest_low, input digest_high, output ready);
endinterface

`default_nettype wire

>>> rtl/core/md5_hash_engine_top.sv
// Top level of the MD5 hash engine: sequencer, chaining words, bit length and
// digest register. Depends on md5_pkg, md5_if, md5_round and md5_blk_buf.
`default_nettype none

// The engine takes one beat per cycle while it gathers message bytes. A beat
// whose byte completes a 64-byte block starts a compression of 64 rounds on
// the single shared round unit, one round per cycle, followed by the
// chaining-word update, and the input is not ready until both are done. A
// beat that ends the message pads the block and runs one compression, or two
// when fewer than nine bytes remain in the block, and the input stays not
// ready meanwhile; a full block completed by that same beat is compressed
// first. The digest is held in an output register until it is taken; the
// engine accepts further bytes meanwhile, and only stalls before writing the
// next digest if the previous one is still waiting. After each digest the
// engine returns to the initial vector.
module md5_hash_engine_top
    import md5_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    md5_in_if.sink     i_in,
    md5_out_if.source  o_out
);

    t_state      r_state, n_state;
    t_blk_kind   r_kind;
    logic        r_end_pend;
    logic [63:0] r_len;
    logic [5:0]  r_round;
    logic [31:0] r_chain [4];
    logic [31:0] r_wa, r_wb, r_wc, r_wd;
    logic        r_out_valid;
    logic [63:0] r_dig_lo, r_dig_hi;

    t_buf_cmd    buf_cmd;
    logic [3:0]  msg_idx;
    logic [31:0] msg_word;
    logic [31:0] new_b;
    logic        in_beat;
    logic [5:0]  byte_pos;
    logic [5:0]  pad_pos;
    logic        out_free;

    assign in_beat  = i_in.valid && i_in.ready;
    assign byte_pos = r_len[8:3];
    assign pad_pos  = r_len[8:3];
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.digest_low  = r_dig_lo;
    assign o_out.digest_high = r_dig_hi;

    // Shared round unit and block buffer.
    md5_round u_round (
        .i_round    (r_round),
        .i_a        (r_wa),
        .i_b        (r_wb),
        .i_c        (r_wc),
        .i_d        (r_wd),
        .i_msg_word (msg_word),
        .o_msg_idx  (msg_idx),
        .o_new_b    (new_b)
    );

    md5_blk_buf u_buf (
        .i_clk     (i_clk),
        .i_cmd     (buf_cmd),
        .i_rd_idx  (msg_idx),
        .o_rd_word (msg_word)
    );

    // Commands to the block buffer.
    always_comb begin
        buf_cmd          = '0;
        buf_cmd.byte_pos = byte_pos;
        buf_cmd.byte_val = i_in.data_byte;
        buf_cmd.pad_pos  = pad_pos;
        buf_cmd.bit_len  = r_len;
        unique case (r_state)
            ST_IDLE: begin
                buf_cmd.wr_byte = in_beat && i_in.byte_present;
            end
            ST_PAD: begin
                buf_cmd.pad     = 1'b1;
                buf_cmd.put_len = (pad_pos < LEN_START);
            end
            ST_ZERO: begin
                buf_cmd.clear   = 1'b1;
                buf_cmd.put_len = 1'b1;
            end
            default: begin
                buf_cmd.wr_byte = 1'b0;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    if (i_in.byte_present && (byte_pos == LAST_BYTE)) begin
                        n_state = ST_ROUND;
                    end else if (i_in.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD:   n_state = ST_ROUND;
            ST_ZERO:  n_state = ST_ROUND;
            ST_ROUND: begin
                if (r_round == LAST_ROUND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                unique case (r_kind)
                    BLK_PAD:  n_state = ST_ZERO;
                    BLK_LAST: n_state = ST_EMIT;
                    default:  n_state = r_end_pend ? ST_PAD : ST_IDLE;
                endcase
            end
            default: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= BLK_DATA;
            r_end_pend  <= 1'b0;
            r_len       <= 64'd0;
            r_round     <= 6'd0;
            r_out_valid <= 1'b0;
            r_chain[0]  <= IV_A;
            r_chain[1]  <= IV_B;
            r_chain[2]  <= IV_C;
            r_chain[3]  <= IV_D;
        end else begin
            r_state <= n_state;

            // Digest handshake: a new digest sets the flag, taking the beat clears it.
            if ((r_state == ST_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_end_pend <= i_in.end_of_message;
                        r_kind     <= BLK_DATA;
                        if (i_in.byte_present) begin
                            r_len <= r_len + 64'd8;
                        end
                    end
                end
                ST_PAD: begin
                    r_end_pend <= 1'b0;
                    r_kind     <= (pad_pos < LEN_START) ? BLK_LAST : BLK_PAD;
                end
                ST_ZERO: begin
                    r_kind <= BLK_LAST;
                end
                ST_ROUND: begin
                    r_round <= r_round + 6'd1;
                end
                ST_ADD: begin
                    r_chain[0] <= r_chain[0] + r_wa;
                    r_chain[1] <= r_chain[1] + r_wb;
                    r_chain[2] <= r_chain[2] + r_wc;
                    r_chain[3] <= r_chain[3] + r_wd;
                end
                default: begin
                    if (out_free) begin
                        r_len       <= 64'd0;
                        r_chain[0]  <= IV_A;
                        r_chain[1]  <= IV_B;
                        r_chain[2]  <= IV_C;
                        r_chain[3]  <= IV_D;
                    end
                end
            endcase
        end
    end

    // Working words: loaded from the chaining words when a compression starts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa <= 32'd0;
            r_wb <= 32'd0;
            r_wc <= 32'd0;
            r_wd <= 32'd0;
        end else if ((n_state == ST_ROUND) && (r_state != ST_ROUND)) begin
            r_wa <= r_chain[0];
            r_wb <= r_chain[1];
            r_wc <= r_chain[2];
            r_wd <= r_chain[3];
        end else if (r_state == ST_ROUND) begin
            r_wa <= r_wd;
            r_wb <= new_b;
            r_wc <= r_wb;
            r_wd <= r_wc;
        end
    end

    // Digest register, little-endian words.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && out_free) begin
            r_dig_lo <= {r_chain[1], r_chain[0]};
            r_dig_hi <= {r_chain[3], r_chain[2]};
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/md5_round.sv
// Shared MD5 round unit: boolean function, message index, add and rotate.
// Depends on md5_pkg for the round constants and rotate amounts.
`default_nettype none

module md5_round
    import md5_pkg::*;
(
    input  wire logic [5:0]  i_round,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic [31:0] i_c,
    input  wire logic [31:0] i_d,
    input  wire logic [31:0] i_msg_word,
    output logic      [3:0]  o_msg_idx,
    output logic      [31:0] o_new_b
);

    logic [31:0] f_val;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [4:0]  rot_amt;

    // Boolean function and message word index for the quarter in use.
    always_comb begin
        f_val     = 32'd0;
        o_msg_idx = 4'd0;
        unique case (i_round[5:4])
            2'd0: begin
                f_val     = (i_b & i_c) | (~i_b & i_d);
                o_msg_idx = i_round[3:0];
            end
            2'd1: begin
                f_val     = (i_d & i_b) | (~i_d & i_c);
                o_msg_idx = {i_round[1:0], 2'b00} + i_round[3:0] + 4'd1;
            end
            2'd2: begin
                f_val     = i_b ^ i_c ^ i_d;
                o_msg_idx = {i_round[2:0], 1'b0} + i_round[3:0] + 4'd5;
            end
            default: begin
                f_val     = i_c ^ (i_b | ~i_d);
                o_msg_idx = {i_round[0], 3'b000} - i_round[3:0];
            end
        endcase
    end

    // Sum, left rotate and final add onto b.
    always_comb begin
        sum      = i_a + f_val + K_TABLE[i_round] + i_msg_word;
        rot_amt  = f_rot_amount(i_round);
        rot_wide = {sum, sum} << rot_amt;
        o_new_b  = i_b + rot_wide[63:32];
    end

endmodule

`default_nettype wire

>>> rtl/core/md5_blk_buf.sv
// Block buffer of the MD5 hash engine: sixteen message words with byte
// writes, padding, clearing and length insertion. Depends on md5_pkg.
`default_nettype none

module md5_blk_buf
    import md5_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_buf_cmd    i_cmd,
    input  wire logic [3:0]  i_rd_idx,
    output logic      [31:0] o_rd_word
);

    logic [31:0] r_words [16];
    logic [31:0] n_words [16];

    // Next contents: byte write, padding mask, clear, then the bit length on top.
    always_comb begin
        for (int w = 0; w < 16; w++) begin
            n_words[w] = r_words[w];
            for (int l = 0; l < 4; l++) begin
                if (i_cmd.wr_byte && (i_cmd.byte_pos == 6'(w * 4 + l))) begin
                    n_words[w][l*8 +: 8] = i_cmd.byte_val;
                end
                if (i_cmd.pad) begin
                    if (i_cmd.pad_pos == 6'(w * 4 + l)) begin
                        n_words[w][l*8 +: 8] = PAD_BYTE;
                    end else if (6'(w * 4 + l) > i_cmd.pad_pos) begin
                        n_words[w][l*8 +: 8] = 8'h00;
                    end
                end
            end
            if (i_cmd.clear) begin
                n_words[w] = 32'd0;
            end
        end
        if (i_cmd.put_len) begin
            n_words[LEN_WORD_LO] = i_cmd.bit_len[31:0];
            n_words[LEN_WORD_HI] = i_cmd.bit_len[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        r_words <= n_words;
    end

    assign o_rd_word = r_words[i_rd_idx];

endmodule

`default_nettype wire
